### hw/rtl/rau_pkg.sv
// Shared types and codes for the rational arithmetic unit.
// No dependencies; imported by every module of the block.
package rau_pkg;

  localparam int unsigned DW  = 64;
  localparam int unsigned OPW = 32;
  localparam int unsigned DNW = 31;
  localparam int unsigned CW  = 6;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_DEN_ZERO = 2'd2
  } status_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_COMB,
    S_ABSN,
    S_ABSD,
    S_TWOS,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_SIGN,
    S_DONE
  } state_e;

  typedef struct packed {
    act_e                   action;
    logic signed [OPW-1:0]  a_num;
    logic        [DNW-1:0]  a_den;
    logic signed [OPW-1:0]  b_num;
    logic        [DNW-1:0]  b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [DW-1:0]   res_num;
    logic        [DW-2:0]   res_den;
    status_e                status;
  } rau_out_t;

  typedef struct packed {
    alu_op_e          op;
    logic [DW-1:0]    a;
    logic [DW-1:0]    b;
  } alu_req_t;

  typedef struct packed {
    logic [DW-1:0]    res;
    logic             borrow;
  } alu_rsp_t;

endpackage

### hw/rtl/rau_mul.sv
// Registered 32x32 signed multiplier shared by all cross products.
// Depends on rau_pkg.
module rau_mul (
  input  logic                               clk_i,
  input  logic signed [rau_pkg::OPW-1:0]     op_a_i,
  input  logic signed [rau_pkg::OPW-1:0]     op_b_i,
  output logic signed [rau_pkg::DW-1:0]      prod_o
);
  import rau_pkg::*;

  logic signed [DW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= DW'(op_a_i * op_b_i);
  end

  assign prod_o = prod_q;

endmodule

### hw/rtl/rau_alu.sv
// Shared 64-bit add/subtract unit with unsigned borrow out.
// Depends on rau_pkg.
module rau_alu (
  input  rau_pkg::alu_req_t req_i,
  output rau_pkg::alu_rsp_t rsp_o
);
  import rau_pkg::*;

  logic          is_sub;
  logic [DW-1:0] b_x;
  logic [DW:0]   sum;

  assign is_sub = (req_i.op == ALU_SUB);
  assign b_x    = is_sub ? ~req_i.b : req_i.b;
  assign sum    = {1'b0, req_i.a} + {1'b0, b_x} + (DW+1)'(is_sub);

  // borrow means a < b (unsigned) on a subtract
  assign rsp_o.res    = sum[DW-1:0];
  assign rsp_o.borrow = is_sub & ~sum[DW];

endmodule

### hw/rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit: takes a/b-style fraction pairs plus an operation
// (add, subtract, multiply, divide) and returns the exact result reduced to
// lowest terms with a positive denominator; a zero numerator comes back as 0/1,
// a zero operand denominator or a divide by a zero fraction as 0/0 with a
// status code. One item is worked at a time: in_stall_o stays high from the
// accepting edge until the result is moved into the output register, which
// frees the input side even while that result beat waits on out_stall_i.
// Each item passes the shared 32x32 multiplier for three cross products, the
// shared 64-bit add/subtract unit for the sum and magnitudes, one shift step
// per common factor of two, a binary GCD of one subtract or shift per cycle,
// then two 64-step restoring divisions that run on the same add/subtract unit.
// Error items go from the accepting edge straight to S_DONE; items whose result
// numerator is zero reach S_DONE after S_MUL0, S_MUL1, S_MUL2, S_COMB and S_ABSN.
// OPERAND_WIDTH (8..32) selects
// how many low bits of the numerator fields (and OPERAND_WIDTH-1 of the
// denominator fields) are used.
// Depends on rau_pkg, rau_mul and rau_alu.
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rau_pkg::rau_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rau_pkg::rau_out_t out_data_o
);
  import rau_pkg::*;

  state_e state_q, state_d;

  // operands, sign extended / zero extended to the multiplier width
  act_e                  act_q, act_d;
  logic signed [OPW-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic signed [OPW-1:0] an_ext, ad_ext, bn_ext, bd_ext;

  // x: numerator / its magnitude / quotient, y: same for the denominator
  // u, v: GCD work pair; u doubles as the division remainder
  logic [DW-1:0] x_q, x_d, y_q, y_d, u_q, u_d, v_q, v_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          neg_q, neg_d;
  status_e       status_q, status_d;

  logic          out_valid_q, out_valid_d;
  rau_out_t      out_data_q, out_data_d;

  logic signed [OPW-1:0] mul_a, mul_b;
  logic signed [DW-1:0]  prod;
  alu_req_t              alu_req;
  alu_rsp_t              alu_rsp;
  logic [DW-1:0]         rem_sh, ymag;
  logic                  out_free;

  rau_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  rau_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign an_ext = OPW'($signed(in_data_i.a_num[OPERAND_WIDTH-1:0]));
  assign bn_ext = OPW'($signed(in_data_i.b_num[OPERAND_WIDTH-1:0]));
  assign ad_ext = OPW'(in_data_i.a_den[OPERAND_WIDTH-2:0]);
  assign bd_ext = OPW'(in_data_i.b_den[OPERAND_WIDTH-2:0]);

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    an_q       <= an_d;
    ad_q       <= ad_d;
    bn_q       <= bn_d;
    bd_q       <= bd_d;
    x_q        <= x_d;
    y_q        <= y_d;
    u_q        <= u_d;
    v_q        <= v_d;
    cnt_q      <= cnt_d;
    neg_q      <= neg_d;
    status_q   <= status_d;
    out_data_q <= out_data_d;
  end

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    an_d        = an_q;
    ad_d        = ad_q;
    bn_d        = bn_q;
    bd_d        = bd_q;
    x_d         = x_q;
    y_d         = y_q;
    u_d         = u_q;
    v_d         = v_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    status_d    = status_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_a       = an_q;
    mul_b       = bd_q;
    alu_req     = '{op: ALU_SUB, a: x_q, b: y_q};
    rem_sh      = '0;
    ymag        = y_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d = in_data_i.action;
          an_d  = an_ext;
          ad_d  = ad_ext;
          bn_d  = bn_ext;
          bd_d  = bd_ext;
          x_d   = '0;
          y_d   = '0;
          // zero denominator outranks divide by zero
          if (ad_ext == '0 || bd_ext == '0) begin
            status_d = ST_DEN_ZERO;
            state_d  = S_DONE;
          end else if (in_data_i.action == ACT_DIV && bn_ext == '0) begin
            status_d = ST_DIV_ZERO;
            state_d  = S_DONE;
          end else begin
            status_d = ST_OK;
            state_d  = S_MUL0;
          end
        end
      end
      S_MUL0: begin
        mul_a   = an_q;
        mul_b   = (act_q == ACT_MUL) ? bn_q : bd_q;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        mul_a   = bn_q;
        mul_b   = ad_q;
        x_d     = prod;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        mul_a   = ad_q;
        mul_b   = (act_q == ACT_DIV) ? bn_q : bd_q;
        y_d     = prod;
        state_d = S_COMB;
      end
      S_COMB: begin
        alu_req = '{op: (act_q == ACT_ADD) ? ALU_ADD : ALU_SUB, a: x_q, b: y_q};
        if (act_q == ACT_ADD || act_q == ACT_SUB) begin
          x_d = alu_rsp.res;
        end
        y_d     = prod;
        state_d = S_ABSN;
      end
      S_ABSN: begin
        alu_req = '{op: ALU_SUB, a: '0, b: x_q};
        if (x_q == '0) begin
          x_d     = '0;
          y_d     = DW'(1);
          state_d = S_DONE;
        end else begin
          neg_d   = x_q[DW-1] ^ y_q[DW-1];
          x_d     = x_q[DW-1] ? alu_rsp.res : x_q;
          state_d = S_ABSD;
        end
      end
      S_ABSD: begin
        alu_req = '{op: ALU_SUB, a: '0, b: y_q};
        ymag    = y_q[DW-1] ? alu_rsp.res : y_q;
        y_d     = ymag;
        u_d     = x_q;
        v_d     = ymag;
        state_d = S_TWOS;
      end
      S_TWOS: begin
        // strip common factors of two from both the pair and the operands
        if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          x_d = x_q >> 1;
          y_d = y_q >> 1;
        end else begin
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        alu_req = '{op: ALU_SUB, a: u_q, b: v_q};
        priority if (u_q == '0) begin
          // v holds the odd part of the gcd; u now serves as remainder
          cnt_d   = '1;
          state_d = S_DIVN;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (alu_rsp.borrow) begin
          u_d = v_q;
          v_d = u_q;
        end else begin
          u_d = alu_rsp.res >> 1;
        end
      end
      S_DIVN: begin
        rem_sh  = {u_q[DW-2:0], x_q[DW-1]};
        alu_req = '{op: ALU_SUB, a: rem_sh, b: v_q};
        x_d     = {x_q[DW-2:0], ~alu_rsp.borrow};
        u_d     = alu_rsp.borrow ? rem_sh : alu_rsp.res;
        cnt_d   = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          u_d     = '0;
          cnt_d   = '1;
          state_d = S_DIVD;
        end
      end
      S_DIVD: begin
        rem_sh  = {u_q[DW-2:0], y_q[DW-1]};
        alu_req = '{op: ALU_SUB, a: rem_sh, b: v_q};
        y_d     = {y_q[DW-2:0], ~alu_rsp.borrow};
        u_d     = alu_rsp.borrow ? rem_sh : alu_rsp.res;
        cnt_d   = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = S_SIGN;
        end
      end
      S_SIGN: begin
        alu_req = '{op: ALU_SUB, a: '0, b: x_q};
        if (neg_q) begin
          x_d = alu_rsp.res;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_data_d  = '{res_num: x_q, res_den: y_q[DW-2:0], status: status_q};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/rau_checker.sv
// Port-level checks for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg and rational_arithmetic_unit.
module rau_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input rau_pkg::rau_out_t out_data_o
);
  import rau_pkg::*;

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result beat changed while stalled");

  // one item at a time: the input closes right after a beat is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input open directly after accept");

  // zero denominator exactly on error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.res_den == '0) == (out_data_o.status != ST_OK)))
    else $error("denominator and status disagree");

  // a zero result is reported as 0/1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_OK && out_data_o.res_num == '0)
      |-> (out_data_o.res_den == (DW-1)'(1)))
    else $error("zero result not reduced to 0/1");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
